// ----- design/lift_pid_ramp_controller_defines.svh -----
// Assertion macros used by the lift controller top level.
`ifndef LIFT_PID_RAMP_CONTROLLER_DEFINES_SVH
`define LIFT_PID_RAMP_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define LPRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LPRC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define LPRC_ASSERT(lbl, prop, msg)
`define LPRC_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ----- design/lprc_pkg.sv -----
package lprc_pkg;

  // Slew rate, Q7.9 drive change per second.
  localparam logic [15:0] RAMP_RATE = 16'd1024;

  localparam int unsigned CFG_AW = 5;

  localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [2:0] REG_HOLD_DRIVE    = 3'd3;
  localparam logic [2:0] REG_DRIVE_LIMIT   = 3'd4;
  localparam logic [2:0] REG_TOP_HEIGHT    = 3'd5;
  localparam logic [2:0] REG_DEAD_BAND     = 3'd6;
  localparam logic [2:0] REG_BOTTOM_HEIGHT = 3'd7;

  localparam logic [1:0] MODE_HOLD  = 2'd0;
  localparam logic [1:0] MODE_REST  = 2'd1;
  localparam logic [1:0] MODE_TRACK = 2'd2;

  typedef enum logic [2:0] {
    MUL_PE,
    MUL_IE,
    MUL_IT,
    MUL_DE,
    MUL_DT,
    MUL_RS
  } mul_sel_e;

  typedef struct packed {
    logic        [15:0] prop_gain;
    logic        [15:0] integ_gain;
    logic        [15:0] deriv_gain;
    logic signed [15:0] hold_drive;
    logic        [14:0] drive_limit;
    logic signed [15:0] top_height;
    logic        [14:0] dead_band;
    logic signed [15:0] bottom_height;
  } cfg_t;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     load_in;
    logic     take_p;
    logic     take_integ;
    logic     take_d;
    logic     take_step;
    logic     calc_want;
    logic     calc_next;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic tracking;
  } sts_t;

endpackage

// ----- design/lprc_regs.sv -----
module lprc_regs
  import lprc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:2])
        REG_PROP_GAIN:     cfg_d.prop_gain     = pwdata[15:0];
        REG_INTEG_GAIN:    cfg_d.integ_gain    = pwdata[15:0];
        REG_DERIV_GAIN:    cfg_d.deriv_gain    = pwdata[15:0];
        REG_HOLD_DRIVE:    cfg_d.hold_drive    = pwdata[15:0];
        REG_DRIVE_LIMIT:   cfg_d.drive_limit   = pwdata[14:0];
        REG_TOP_HEIGHT:    cfg_d.top_height    = pwdata[15:0];
        REG_DEAD_BAND:     cfg_d.dead_band     = pwdata[14:0];
        REG_BOTTOM_HEIGHT: cfg_d.bottom_height = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PROP_GAIN:     prdata = 32'(cfg_q.prop_gain);
      REG_INTEG_GAIN:    prdata = 32'(cfg_q.integ_gain);
      REG_DERIV_GAIN:    prdata = 32'(cfg_q.deriv_gain);
      REG_HOLD_DRIVE:    prdata = {16'd0, cfg_q.hold_drive};
      REG_DRIVE_LIMIT:   prdata = 32'(cfg_q.drive_limit);
      REG_TOP_HEIGHT:    prdata = {16'd0, cfg_q.top_height};
      REG_DEAD_BAND:     prdata = 32'(cfg_q.dead_band);
      REG_BOTTOM_HEIGHT: prdata = {16'd0, cfg_q.bottom_height};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= '0;
      cfg_q.integ_gain    <= '0;
      cfg_q.deriv_gain    <= '0;
      cfg_q.hold_drive    <= '0;
      cfg_q.drive_limit   <= 15'h7FFF;
      cfg_q.top_height    <= 16'sh7FFF;
      cfg_q.dead_band     <= '0;
      cfg_q.bottom_height <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/lprc_ctrl.sv -----
module lprc_ctrl
  import lprc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MPE  = 4'd1;
  localparam logic [3:0] S_MIE  = 4'd2;
  localparam logic [3:0] S_MIT  = 4'd3;
  localparam logic [3:0] S_MDE  = 4'd4;
  localparam logic [3:0] S_MDT  = 4'd5;
  localparam logic [3:0] S_MRS  = 4'd6;
  localparam logic [3:0] S_WANT = 4'd7;
  localparam logic [3:0] S_SLEW = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_PE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_MPE;
        end
      end
      S_MPE: begin
        cmd_o.mul_sel = MUL_PE;
        state_d = sts_i.tracking ? S_MIE : S_MRS;
      end
      S_MIE: begin
        cmd_o.take_p  = 1'b1;
        cmd_o.mul_sel = MUL_IE;
        state_d = S_MIT;
      end
      S_MIT: begin
        cmd_o.mul_sel = MUL_IT;
        state_d = S_MDE;
      end
      S_MDE: begin
        cmd_o.take_integ = 1'b1;
        cmd_o.mul_sel    = MUL_DE;
        state_d = S_MDT;
      end
      S_MDT: begin
        cmd_o.mul_sel = MUL_DT;
        state_d = S_MRS;
      end
      S_MRS: begin
        cmd_o.take_d  = 1'b1;
        cmd_o.mul_sel = MUL_RS;
        state_d = S_WANT;
      end
      S_WANT: begin
        cmd_o.take_step = 1'b1;
        cmd_o.calc_want = 1'b1;
        state_d = S_SLEW;
      end
      S_SLEW: begin
        cmd_o.calc_next = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/lprc_dp.sv -----
module lprc_dp
  import lprc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic signed [15:0] target_height_i,
  input  logic signed [15:0] measured_height_i,
  input  logic        [15:0] tick_time_i,
  output logic signed [15:0] motor_drive_o,
  output logic        [1:0]  loop_mode_o,
  output logic               top_clamped_o
);

  logic signed [15:0] tgt_q, meas_q;
  logic        [15:0] dt_q;

  logic signed [31:0] integ_q, integ_d;
  logic signed [16:0] last_err_q;
  logic signed [15:0] present_q;

  logic signed [53:0] prod_q;
  logic signed [31:0] p_q;
  logic signed [34:0] d_q;
  logic        [22:0] step_q;
  logic signed [15:0] want_q, want_d;
  logic signed [24:0] next_q, next_d;

  logic signed [15:0] drive_q;
  logic        [1:0]  mode_q;
  logic               clamped_q;

  logic signed [16:0] err;
  logic        [16:0] aerr;
  logic signed [17:0] de;
  logic        [1:0]  mode;
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul;
  logic signed [45:0] inc;
  logic signed [46:0] isum;
  logic signed [22:0] integ_sh;
  logic signed [36:0] psum;
  logic signed [16:0] diff;
  logic        [16:0] adiff;
  logic signed [24:0] lim_s;
  logic signed [15:0] drive;
  logic               cut;

  assign err  = 17'(tgt_q) - 17'(meas_q);
  assign aerr = err[16] ? 17'(-err) : 17'(err);
  assign de   = 18'(err) - 18'(last_err_q);

  always_comb begin
    if ((aerr < 17'(cfg_i.dead_band)) && (meas_q > cfg_i.bottom_height)) begin
      mode = MODE_HOLD;
    end else if ((tgt_q < cfg_i.bottom_height) && (meas_q < cfg_i.bottom_height)) begin
      mode = MODE_REST;
    end else begin
      mode = MODE_TRACK;
    end
  end

  assign sts_o.tracking = (mode == MODE_TRACK);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_PE: begin
        mul_a = 36'(err);
        mul_b = 18'(cfg_i.prop_gain);
      end
      MUL_IE: begin
        mul_a = 36'(err);
        mul_b = 18'(cfg_i.integ_gain);
      end
      MUL_IT: begin
        mul_a = prod_q[35:0];
        mul_b = 18'(dt_q);
      end
      MUL_DE: begin
        mul_a = 36'(de);
        mul_b = 18'(cfg_i.deriv_gain);
      end
      MUL_DT: begin
        mul_a = prod_q[35:0];
        mul_b = 18'(dt_q);
      end
      MUL_RS: begin
        mul_a = 36'(dt_q);
        mul_b = 18'(RAMP_RATE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul = mul_a * mul_b;

  assign inc  = prod_q[53:8];
  assign isum = 47'(integ_q) + 47'(inc);

  always_comb begin
    if (isum[46:31] == {16{isum[46]}}) begin
      integ_d = isum[31:0];
    end else if (isum[46]) begin
      integ_d = 32'sh8000_0000;
    end else begin
      integ_d = 32'sh7FFF_FFFF;
    end
  end

  assign integ_sh = integ_q[31:9];
  assign psum     = 37'(p_q) + 37'(integ_sh) + 37'(d_q) + 37'(cfg_i.hold_drive);

  always_comb begin
    if (mode == MODE_HOLD) begin
      want_d = cfg_i.hold_drive;
    end else if (mode == MODE_REST) begin
      want_d = '0;
    end else if (psum[36:15] == {22{psum[36]}}) begin
      want_d = psum[15:0];
    end else if (psum[36]) begin
      want_d = 16'sh8000;
    end else begin
      want_d = 16'sh7FFF;
    end
  end

  assign diff  = 17'(want_q) - 17'(present_q);
  assign adiff = diff[16] ? 17'(-diff) : 17'(diff);

  always_comb begin
    if (23'(adiff) < step_q) begin
      next_d = 25'(want_q);
    end else if (diff > 17'sd0) begin
      next_d = 25'(present_q) + 25'(step_q);
    end else if (diff < 17'sd0) begin
      next_d = 25'(present_q) - 25'(step_q);
    end else begin
      next_d = 25'(present_q);
    end
  end

  assign lim_s = 25'(cfg_i.drive_limit);
  assign cut   = (meas_q > cfg_i.top_height) && (next_q > 25'(cfg_i.hold_drive));

  always_comb begin
    if (cut) begin
      drive = cfg_i.hold_drive;
    end else if (next_q > lim_s) begin
      drive = 16'(lim_s);
    end else if (next_q < -lim_s) begin
      drive = 16'(-lim_s);
    end else begin
      drive = next_q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tgt_q  <= target_height_i;
      meas_q <= measured_height_i;
      dt_q   <= tick_time_i;
    end
    prod_q <= mul;
    if (cmd_i.take_p) begin
      p_q <= prod_q[32:1];
    end
    if (cmd_i.take_d) begin
      d_q <= prod_q[51:17];
    end
    if (cmd_i.take_step) begin
      step_q <= prod_q[31:9];
    end
    if (cmd_i.calc_want) begin
      want_q <= want_d;
    end
    if (cmd_i.calc_next) begin
      next_q <= next_d;
    end
    if (cmd_i.load_out) begin
      drive_q   <= drive;
      mode_q    <= mode;
      clamped_q <= cut;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
      present_q  <= '0;
    end else begin
      if (cmd_i.take_integ) begin
        integ_q <= integ_d;
      end
      if (cmd_i.calc_want && (mode == MODE_TRACK)) begin
        last_err_q <= err;
      end
      if (cmd_i.load_out) begin
        present_q <= drive;
      end
    end
  end

  assign motor_drive_o = drive_q;
  assign loop_mode_o   = mode_q;
  assign top_clamped_o = clamped_q;

endmodule

// ----- design/lift_pid_ramp_controller.sv -----
// Lift height controller with PID, gravity feed-forward and a slew-limited drive. Each input
// beat carries one control tick; one output beat with the drive and loop mode follows it.
// In PID tracking mode a tick also passes through the integral and derivative products; a tick
// in hold or rest mode skips them. No new tick is accepted until the current one is done, as
// all products go in sequence through one shared 36 x 18 bit multiplier with a register after
// it. A finished result sits in an output register, so the next tick is accepted while it
// waits; a tick that finishes while the previous result is still untaken waits for it to drain.
`include "lift_pid_ramp_controller_defines.svh"

module lift_pid_ramp_controller
  import lprc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,  // target_height, measured_height, tick_time
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,  // motor_drive, loop_mode, top_clamped, zero fill
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t               cfg;
  cmd_t               cmd;
  sts_t               sts;
  logic signed [15:0] motor_drive;
  logic        [1:0]  loop_mode;
  logic               top_clamped;
  logic signed [16:0] out_drive_s;
  logic signed [16:0] lim_s;

  lprc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lprc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lprc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .target_height_i   (s_axis_tdata[15:0]),
    .measured_height_i (s_axis_tdata[31:16]),
    .tick_time_i       (s_axis_tdata[47:32]),
    .motor_drive_o     (motor_drive),
    .loop_mode_o       (loop_mode),
    .top_clamped_o     (top_clamped)
  );

  assign m_axis_tdata = {5'd0, top_clamped, loop_mode, motor_drive};

  assign out_drive_s = 17'(motor_drive);
  assign lim_s       = 17'(cfg.drive_limit);

  `LPRC_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "Controller took a second tick while busy.")
  `LPRC_ASSERT(a_top_cut_is_hold, m_axis_tvalid && top_clamped |-> motor_drive == cfg.hold_drive, "Top cut drive differs from feed-forward.")
  `LPRC_ASSERT_NEVER(a_drive_in_limit, m_axis_tvalid && !top_clamped && (out_drive_s > lim_s || out_drive_s < -lim_s), "Drive exceeds the limit.")

endmodule
